>>> src/bis_pkg.sv
// ============================================================================
// bis_pkg
// Shared types, command codes and helpers for the bitmap integer set.
// ============================================================================
package bis_pkg;

  localparam int POS_W  = 12;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  typedef logic [1:0]        command_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bit_idx_t;

  localparam command_t CMD_ADD   = 2'd0;
  localparam command_t CMD_CLEAR = 2'd1;
  localparam command_t CMD_FIND  = 2'd2;

  localparam word_t    FULL_WORD = 32'hFFFF_FFFF;
  localparam bit_idx_t BIT_MASK  = 5'h1F;

  // Index of the lowest set bit; zero when the word is empty.
  function automatic bit_idx_t lowest_bit(input word_t w);
    bit_idx_t idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = bit_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> src/bitmap_integer_set.sv
// ============================================================================
// bitmap_integer_set
// Set of small integers held as a bitmap of 32-bit words in one RAM.
// ============================================================================
// A request on the input channel carries a command, a position and a range
// end; each request yields exactly one result on the output channel. Both
// channels use valid/stall and a transfer happens when valid is high and
// stall is low. Requests are handled one at a time by a sequencer that
// reads, modifies and writes back bitmap words, one RAM word per cycle.
// Add reads the addressed word and writes it back with the bit set. Clear
// range walks the covered words in a pipelined read/write stream. Find next
// reads words from the start word upward until a member shows up or the last
// word is checked. Requests that touch no word (out of range, empty range,
// unknown command) have their result waiting in the cycle after acceptance.
// The next request is taken in the cycle after a result loads. After reset
// the block sweeps every RAM word to zero with in_stall held high. A finished
// result sits in an output register; while the receiver stalls, the block
// still accepts and works on the next request and holds its result until the
// output register frees up.
// ============================================================================
module bitmap_integer_set #(
  parameter int WORD_COUNT = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bis_pkg::command_t command,
  input  bis_pkg::pos_t    position,
  input  bis_pkg::pos_t    range_end,
  output logic             out_valid,
  input  logic             out_stall,
  output bis_pkg::pos_t    result_value,
  output logic             was_new,
  output logic             range_error
);

  // Address width of the bitmap RAM.
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // Width that holds the universe size itself.
  localparam int UW = $clog2(WORD_COUNT * 32 + 1);
  // Working width for comparisons against the universe size.
  localparam int VW = (UW > bis_pkg::POS_W) ? UW : bis_pkg::POS_W;
  // Width of a found member before it is cut to the result field.
  localparam int FW = (AW + bis_pkg::BIT_W > bis_pkg::POS_W) ?
                      (AW + bis_pkg::BIT_W) : bis_pkg::POS_W;

  localparam logic [VW-1:0] U_VAL     = VW'(WORD_COUNT * 32);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD_RD = 3'd2;
  localparam logic [2:0] ST_ADD_WR = 3'd3;
  localparam logic [2:0] ST_CLR    = 3'd4;
  localparam logic [2:0] ST_FIND   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            state;
  logic [AW-1:0]         rd_word;     // next word to read (or sweep)
  logic [AW-1:0]         chk_word;    // word whose data is on rdata
  logic                  chk_valid;
  logic                  rd_more;     // clear still has words to read
  logic [AW-1:0]         first_word;
  logic [AW-1:0]         last_word;
  bis_pkg::bit_idx_t     lo_bit;      // first bit of the start word
  bis_pkg::bit_idx_t     hi_bit;      // last bit of the end word (clear)
  bis_pkg::word_t        add_mask;

  bis_pkg::pos_t         res_value;
  logic                  res_new;
  logic                  res_err;

  // RAM interface.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  bis_pkg::word_t        ram_wdata;
  bis_pkg::word_t        ram_rdata;

  bis_ram #(
    .WIDTH(bis_pkg::WORD_W),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_word),
    .rdata(ram_rdata)
  );

  // Request decode, in the working width.
  logic [VW-1:0]         pos_ext;
  logic [VW-1:0]         end_ext;
  logic [VW-1:0]         hi_ext;
  logic [VW-1:0]         hi_m1;
  logic                  accept;

  assign pos_ext  = VW'(position);
  assign end_ext  = VW'(range_end);
  assign hi_ext   = (end_ext < U_VAL) ? end_ext : U_VAL;
  assign hi_m1    = hi_ext - VW'(1);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Masks for the word currently on the read data.
  bis_pkg::word_t        clr_mask;
  bis_pkg::word_t        find_bits;
  logic [FW-1:0]         found_ext;
  logic                  out_free;

  assign clr_mask =
    ((chk_word == first_word) ? (bis_pkg::FULL_WORD << lo_bit) : bis_pkg::FULL_WORD) &
    ((chk_word == last_word) ? (bis_pkg::FULL_WORD >> (bis_pkg::BIT_MASK - hi_bit))
                             : bis_pkg::FULL_WORD);
  assign find_bits = ram_rdata &
    ((chk_word == first_word) ? (bis_pkg::FULL_WORD << lo_bit) : bis_pkg::FULL_WORD);
  assign found_ext = FW'({chk_word, bis_pkg::lowest_bit(find_bits)});
  assign out_free  = !out_valid || !out_stall;

  // Write port: reset sweep, add write-back and clear write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_word;
    ram_wdata = '0;
    case (state)
      ST_INIT: begin
        ram_we = 1'b1;
      end
      ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | add_mask;
      end
      ST_CLR: begin
        ram_we    = chk_valid;
        ram_waddr = chk_word;
        ram_wdata = ram_rdata & ~clr_mask;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      rd_word   <= '0;
      chk_valid <= 1'b0;
      rd_more   <= 1'b0;
    end else begin
      case (state)
        ST_INIT: begin
          if (rd_word == LAST_ADDR) begin
            state <= ST_IDLE;
          end else begin
            rd_word <= rd_word + AW'(1);
          end
        end

        ST_IDLE: begin
          if (accept) begin
            res_new    <= 1'b0;
            chk_valid  <= 1'b0;
            rd_word    <= pos_ext[AW+4:5];
            first_word <= pos_ext[AW+4:5];
            last_word  <= hi_m1[AW+4:5];
            lo_bit     <= position[4:0];
            hi_bit     <= hi_m1[4:0];
            add_mask   <= bis_pkg::word_t'(1) << position[4:0];
            case (command)
              bis_pkg::CMD_ADD: begin
                res_value <= position;
                res_err   <= (pos_ext >= U_VAL);
                if (pos_ext >= U_VAL) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_ADD_RD;
                end
              end
              bis_pkg::CMD_CLEAR: begin
                res_value <= hi_ext[bis_pkg::POS_W-1:0];
                res_err   <= (end_ext > U_VAL) || (pos_ext > U_VAL) ||
                             (pos_ext > end_ext);
                if (pos_ext < hi_ext) begin
                  rd_more <= 1'b1;
                  state   <= ST_CLR;
                end else begin
                  state <= ST_DONE;
                end
              end
              bis_pkg::CMD_FIND: begin
                // The walk replaces this with the member it finds.
                res_value <= U_VAL[bis_pkg::POS_W-1:0];
                res_err   <= (pos_ext > U_VAL);
                if (pos_ext >= U_VAL) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_FIND;
                end
              end
              default: begin
                res_value <= '0;
                res_err   <= 1'b0;
                state     <= ST_DONE;
              end
            endcase
          end
        end

        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end

        ST_ADD_WR: begin
          res_new <= ((ram_rdata & add_mask) == '0);
          state   <= ST_DONE;
        end

        // Read of word n+1 overlaps the write-back of word n.
        ST_CLR: begin
          if (rd_more) begin
            chk_valid <= 1'b1;
            chk_word  <= rd_word;
            if (rd_word == last_word) begin
              rd_more <= 1'b0;
            end else begin
              rd_word <= rd_word + AW'(1);
            end
          end else begin
            chk_valid <= 1'b0;
            if (!chk_valid) begin
              state <= ST_DONE;
            end
          end
        end

        // Reads run one word ahead of the check; the address saturates at
        // the last word so that it never leaves the RAM.
        ST_FIND: begin
          chk_valid <= 1'b1;
          chk_word  <= rd_word;
          if (rd_word != LAST_ADDR) begin
            rd_word <= rd_word + AW'(1);
          end
          if (chk_valid) begin
            if (find_bits != '0) begin
              res_value <= found_ext[bis_pkg::POS_W-1:0];
              state     <= ST_DONE;
            end else if (chk_word == LAST_ADDR) begin
              res_value <= U_VAL[bis_pkg::POS_W-1:0];
              state     <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      result_value <= res_value;
      was_new      <= res_new;
      range_error  <= res_err;
    end
  end

endmodule

>>> src/bis_ram.sv
// ============================================================================
// bis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
